/* rtl/core_hotplug_load_governor_assert.svh */
// Assertion macros for the hotplug load governor.
// Used by the top level; no other dependencies.
`ifndef CORE_HOTPLUG_LOAD_GOVERNOR_ASSERT_SVH
`define CORE_HOTPLUG_LOAD_GOVERNOR_ASSERT_SVH
`ifndef SYNTHESIS
`define CHLG_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("chlg: same-cycle check failed");
`define CHLG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("chlg: next-cycle check failed");
`else
`define CHLG_ASSERT_IMPLY(label, ante, cons)
`define CHLG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/chlg_pkg.sv */
// Shared types, codes and constants for the hotplug load governor.
// No dependencies; imported by every module of the block.
package chlg_pkg;

    localparam int unsigned WINDOW_LEN      = 25;
    localparam int unsigned LOAD_W          = 16;
    localparam int unsigned TASK_W          = 10;
    localparam int unsigned ONLINE_W        = 4;
    localparam int unsigned OFFLINE_W       = 10;
    localparam int unsigned DELAY_W         = 7;
    localparam int unsigned ACTION_W        = 3;
    localparam int unsigned OP_W            = 2;

    localparam int unsigned TASK_SCALE      = 100;
    localparam int unsigned ENABLE_PER_CORE = 100;
    localparam int unsigned BOOST_MIN_CORES = 2;
    localparam int unsigned DELAY_MAX       = 127;
    localparam int unsigned LOAD_MAX        = (2 ** LOAD_W) - 1;
    localparam logic        BOOST_MASK      = 1'b0;

    localparam int unsigned SCALED_W   = TASK_W + $clog2(TASK_SCALE);
    localparam int unsigned SQ_W       = 2 * ONLINE_W;
    localparam int unsigned ENABLE_W   = $clog2(ENABLE_PER_CORE * ((2 ** ONLINE_W) - 1) + 1);
    localparam int unsigned OFF_THR_W  = OFFLINE_W + ONLINE_W;

    localparam int unsigned POS_W      = $clog2(WINDOW_LEN);
    localparam int unsigned SUM_W      = $clog2(WINDOW_LEN * LOAD_MAX + 1);
    localparam int unsigned DIV_SHIFT  = SUM_W + $clog2(WINDOW_LEN);
    localparam longint unsigned DIV_MUL =
        ((64'd1 << DIV_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int unsigned MUL_W      = $clog2(DIV_MUL + 1);
    localparam int unsigned PROD_W     = SUM_W + MUL_W;
    localparam logic [MUL_W-1:0] DIV_MUL_C = MUL_W'(DIV_MUL);

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned PADDR_W     = 4;
    localparam int unsigned PDATA_W     = 32;
    localparam int unsigned REG_IDX_W   = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_MIN_ONLINE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CORES_AVAIL  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_OFFLINE_LOAD = 2'd2;

    localparam logic [ONLINE_W-1:0]  RST_MIN_ONLINE   = 4'd1;
    localparam logic [ONLINE_W-1:0]  RST_CORES_AVAIL  = 4'd4;
    localparam logic [OFFLINE_W-1:0] RST_OFFLINE_LOAD = 10'd55;

    localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
    localparam logic [OP_W-1:0] OP_BOOST   = 2'd1;
    localparam logic [OP_W-1:0] OP_SUSPEND = 2'd2;
    localparam logic [OP_W-1:0] OP_RESUME  = 2'd3;

    localparam logic [ACTION_W-1:0] ACT_NONE             = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ONLINE_ALL       = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_OFFLINE_ONE      = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_BOOST_ONLINE_ONE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CANCEL_OFFLINE   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_OFFLINE_ALL      = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RESTART          = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [TASK_W-1:0]   runnable_tasks;
        logic [ONLINE_W-1:0] cores_online;
        logic                offline_pending;
        logic                boost_on;
        logic                boost_single;
    } t_in_item;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [LOAD_W-1:0]   average_load;
        logic [DELAY_W-1:0]  delay_periods;
        logic                boost_active_flag;
        logic                boost_oneshot_flag;
        logic                suspended_flag;
    } t_out_item;

    typedef struct packed {
        logic [ONLINE_W-1:0]  min_online;
        logic [ONLINE_W-1:0]  cores_available;
        logic [OFFLINE_W-1:0] offline_load_per_core;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [LOAD_W-1:0]    running;
        logic                 pending;
        logic                 b_on;
        logic                 b_single;
        logic                 below_min;
        logic                 can_raise;
        logic                 above_min;
        logic                 few_online;
        logic                 multi_online;
        logic [ENABLE_W-1:0]  enable_thr;
        logic [OFF_THR_W-1:0] off_thr;
        logic [DELAY_W-1:0]   delay;
    } t_cmd;

endpackage

/* rtl/chlg_front.sv */
// Front end: accepts requests and classifies them against the configuration.
// Depends on chlg_pkg; feeds chlg_queue.
module chlg_front
    import chlg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    input  logic     i_q_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic                 r_valid;
    logic                 n_valid;
    t_cmd                 r_cmd;
    t_cmd                 n_cmd;
    logic                 accept;
    logic [ONLINE_W-1:0]  cores_eff;
    logic [ONLINE_W-1:0]  min_raw;
    logic [ONLINE_W-1:0]  min_eff;
    logic [SCALED_W-1:0]  scaled;
    logic [SQ_W-1:0]      sq;

    assign o_stall = r_valid && i_q_full;
    assign o_push  = r_valid && !i_q_full;
    assign accept  = i_valid && !o_stall;
    assign n_valid = accept || (r_valid && !o_push);
    assign o_cmd   = r_cmd;

    always_comb begin
        cores_eff = (i_cfg.cores_available == '0) ? ONLINE_W'(1) : i_cfg.cores_available;
        min_raw   = (i_cfg.min_online == '0) ? ONLINE_W'(1) : i_cfg.min_online;
        min_eff   = (min_raw > cores_eff) ? cores_eff : min_raw;
        scaled    = SCALED_W'(i_item.runnable_tasks) * SCALED_W'(TASK_SCALE);
        sq        = SQ_W'(i_item.cores_online) * SQ_W'(i_item.cores_online);

        n_cmd.op           = i_item.operation;
        n_cmd.running      = (scaled > SCALED_W'(LOAD_MAX)) ? LOAD_W'(LOAD_MAX)
                                                            : scaled[LOAD_W-1:0];
        n_cmd.pending      = i_item.offline_pending;
        n_cmd.b_on         = i_item.boost_on;
        n_cmd.b_single     = i_item.boost_single;
        n_cmd.below_min    = i_item.cores_online < min_eff;
        n_cmd.can_raise    = i_item.cores_online < cores_eff;
        n_cmd.above_min    = i_item.cores_online > min_eff;
        n_cmd.few_online   = i_item.cores_online < ONLINE_W'(BOOST_MIN_CORES);
        n_cmd.multi_online = i_item.cores_online > ONLINE_W'(1);
        n_cmd.enable_thr   = ENABLE_W'(cores_eff) * ENABLE_W'(ENABLE_PER_CORE);
        n_cmd.off_thr      = OFF_THR_W'(i_cfg.offline_load_per_core)
                           * OFF_THR_W'(i_item.cores_online);
        n_cmd.delay        = (sq > SQ_W'(DELAY_MAX)) ? DELAY_W'(DELAY_MAX) : sq[DELAY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

/* rtl/chlg_queue.sv */
// Short request queue between the front end and the back end.
// Depends on chlg_pkg.
module chlg_queue
    import chlg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* rtl/chlg_back.sv */
// Back end: load window, average by reciprocal multiply, decision and flags.
// Depends on chlg_pkg; fed by chlg_queue.
module chlg_back
    import chlg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_pop,
    input  t_cmd      i_cmd,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic [LOAD_W-1:0] r_ring [WINDOW_LEN];
    logic [POS_W-1:0]  r_pos;
    logic [SUM_W-1:0]  r_sum;
    logic [POS_W-1:0]  n_pos;
    logic [SUM_W-1:0]  n_sum;

    logic              r_s1_valid;
    t_cmd              r_s1_cmd;
    logic [SUM_W-1:0]  r_s1_sum;
    logic              r_s2_valid;
    t_cmd              r_s2_cmd;
    logic [PROD_W-1:0] r_s2_prod;
    logic              r_out_valid;
    t_out_item         r_out_item;
    t_out_item         n_item;

    logic              r_boost_active;
    logic              r_boost_oneshot;
    logic              r_suspended;
    logic              n_boost_active;
    logic              n_boost_oneshot;
    logic              n_suspended;

    logic              out_load;
    logic              s2_free;
    logic              s1_move;
    logic              s1_free;
    logic              ring_upd;
    logic              boost_block;
    logic [LOAD_W-1:0] avg;

    assign out_load = r_s2_valid && (!r_out_valid || !i_stall);
    assign s2_free  = !r_s2_valid || out_load;
    assign s1_move  = r_s1_valid && s2_free;
    assign s1_free  = !r_s1_valid || s1_move;
    assign o_pop    = i_valid && s1_free;
    assign ring_upd = o_pop && (i_cmd.op == OP_SAMPLE);
    assign o_valid  = r_out_valid;
    assign o_item   = r_out_item;

    assign n_sum = r_sum - SUM_W'(r_ring[r_pos]) + SUM_W'(i_cmd.running);
    assign n_pos = (r_pos == POS_W'(WINDOW_LEN - 1)) ? '0 : r_pos + 1'b1;
    assign avg   = r_s2_prod[DIV_SHIFT +: LOAD_W];
    assign boost_block = r_boost_active && r_boost_oneshot && BOOST_MASK;

    always_comb begin
        n_boost_active  = r_boost_active;
        n_boost_oneshot = r_boost_oneshot;
        n_suspended     = r_suspended;
        n_item          = '0;
        unique case (r_s2_cmd.op)
            OP_SAMPLE: begin
                n_item.average_load = avg;
                if ((avg >= LOAD_W'(r_s2_cmd.enable_thr) && r_s2_cmd.can_raise)
                    || r_s2_cmd.below_min) begin
                    n_item.action = ACT_ONLINE_ALL;
                end else if (avg <= LOAD_W'(r_s2_cmd.off_thr) && r_s2_cmd.above_min
                             && !boost_block && !r_s2_cmd.pending) begin
                    n_item.action = ACT_OFFLINE_ONE;
                    if (r_boost_oneshot) begin
                        n_boost_active  = 1'b0;
                        n_boost_oneshot = 1'b0;
                    end
                end else begin
                    n_item.action        = ACT_NONE;
                    n_item.delay_periods = r_s2_cmd.delay;
                end
            end
            OP_BOOST: begin
                if (!r_suspended) begin
                    if (r_s2_cmd.b_single) begin
                        n_boost_oneshot = 1'b1;
                    end
                    if (r_s2_cmd.b_on) begin
                        if (!r_boost_active) begin
                            n_boost_active = 1'b1;
                            if (r_s2_cmd.few_online) begin
                                n_item.action = ACT_BOOST_ONLINE_ONE;
                            end else if (r_s2_cmd.pending) begin
                                n_item.action = ACT_CANCEL_OFFLINE;
                            end
                        end
                    end else begin
                        n_boost_active = 1'b0;
                    end
                end
            end
            OP_SUSPEND: begin
                n_suspended = 1'b1;
                if (r_s2_cmd.multi_online) begin
                    n_item.action = ACT_OFFLINE_ALL;
                end
            end
            OP_RESUME: begin
                n_suspended   = 1'b0;
                n_item.action = ACT_RESTART;
            end
        endcase
        n_item.boost_active_flag  = n_boost_active;
        n_item.boost_oneshot_flag = n_boost_oneshot;
        n_item.suspended_flag     = n_suspended;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_ring[i] <= '0;
            end
            r_pos <= '0;
            r_sum <= '0;
        end else if (ring_upd) begin
            r_ring[r_pos] <= i_cmd.running;
            r_pos         <= n_pos;
            r_sum         <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_s2_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_boost_active  <= 1'b0;
            r_boost_oneshot <= 1'b0;
            r_suspended     <= 1'b0;
        end else begin
            r_s1_valid  <= o_pop || (r_s1_valid && !s1_move);
            r_s2_valid  <= s1_move || (r_s2_valid && !out_load);
            r_out_valid <= out_load || (r_out_valid && i_stall);
            if (out_load) begin
                r_boost_active  <= n_boost_active;
                r_boost_oneshot <= n_boost_oneshot;
                r_suspended     <= n_suspended;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_cmd <= i_cmd;
            r_s1_sum <= n_sum;
        end
        if (s1_move) begin
            r_s2_cmd  <= r_s1_cmd;
            r_s2_prod <= PROD_W'(r_s1_sum) * PROD_W'(DIV_MUL_C);
        end
        if (out_load) begin
            r_out_item <= n_item;
        end
    end

endmodule

/* rtl/core_hotplug_load_governor.sv */
// Top level of the hotplug load governor: configuration registers and the
// front, queue and back units. Depends on chlg_pkg and the assertion header.
//
// Requests enter on i_in_valid / o_in_stall with payload i_in_data; a request
// is taken at a clock edge where i_in_valid is high and o_in_stall is low.
// Operations: sample tick, boost request, suspend, resume. Each request yields
// exactly one result on o_out_valid / i_out_stall with payload o_out_data.
// From acceptance to o_out_valid a request passes the front register, queue slot,
// window-sum stage and reciprocal-multiply stage, with the decision folded into
// the output register.
// Throughput is one request per cycle unless stalled; the window sum is
// a running sum: per-item work is only one add/subtract and one 21x22 multiply.
// While i_out_stall is high the result holds; the two-entry queue and the
// back-end stages keep filling, then o_in_stall rises.
// Registers via APB: min_online at 0x0, cores_available at 0x4,
// offline_load_per_core at 0x8; pready is always high. Write only while idle.
// Synchronous reset clears the load window, running sum, ring position and
// flags, and returns registers to 1, 4 and 55.
`include "core_hotplug_load_governor_assert.svh"

module core_hotplug_load_governor
    import chlg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg                 r_cfg;
    t_cfg                 n_cfg;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;

    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_valid;
    t_cmd                 front_cmd;
    t_cmd                 q_cmd;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            unique case (reg_idx)
                REG_MIN_ONLINE:   n_cfg.min_online            = pwdata[ONLINE_W-1:0];
                REG_CORES_AVAIL:  n_cfg.cores_available       = pwdata[ONLINE_W-1:0];
                REG_OFFLINE_LOAD: n_cfg.offline_load_per_core = pwdata[OFFLINE_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MIN_ONLINE:   prdata = PDATA_W'(r_cfg.min_online);
            REG_CORES_AVAIL:  prdata = PDATA_W'(r_cfg.cores_available);
            REG_OFFLINE_LOAD: prdata = PDATA_W'(r_cfg.offline_load_per_core);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_online            <= RST_MIN_ONLINE;
            r_cfg.cores_available       <= RST_CORES_AVAIL;
            r_cfg.offline_load_per_core <= RST_OFFLINE_LOAD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    chlg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_item   (i_in_data),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (front_cmd)
    );

    chlg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    chlg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_cmd   (q_cmd),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_data)
    );

    `CHLG_ASSERT_IMPLY(a_boost_action_flag, o_out_valid && (o_out_data.action == ACT_BOOST_ONLINE_ONE || o_out_data.action == ACT_CANCEL_OFFLINE), o_out_data.boost_active_flag)
    `CHLG_ASSERT_IMPLY(a_delay_only_idle, o_out_valid && o_out_data.delay_periods != '0, o_out_data.action == ACT_NONE)
    `CHLG_ASSERT_IMPLY(a_offline_all_suspended, o_out_valid && o_out_data.action == ACT_OFFLINE_ALL, o_out_data.suspended_flag)
    `CHLG_ASSERT_NEXT(a_cfg_min_write, cfg_wr && reg_idx == REG_MIN_ONLINE, r_cfg.min_online == $past(pwdata[ONLINE_W-1:0]))

endmodule
